[hw/rtl/lcg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_pkg: shared types and constants of the chirp generator
// Register map, quadrant codes, queue depth and the quarter-wave sine entry
// function that builds the lookup table at elaboration.
// ----------------------------------------------------------------------------
package lcg_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 32;

  // Register field widths
  localparam int unsigned START_STEP_BITS   = 32;
  localparam int unsigned STEP_INC_BITS     = 32;
  localparam int unsigned SAMPLE_COUNT_BITS = 24;

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_STEP   = 2'd0,
    REG_STEP_INC     = 2'd1,
    REG_SAMPLE_COUNT = 2'd2
  } reg_idx_e;

  // Quadrant taken from the top two phase bits
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // Depth of the queue between front and back (power of two)
  localparam int unsigned FIFO_DEPTH = 4;

  // pi/2 in Q30, rounded
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;

  // Truncating quotient by shift and subtract. Used only at elaboration.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One quarter-wave sine entry, Q30 Taylor series evaluated in fixed point,
  // scaled to the amplitude range. Used only at elaboration.
  function automatic logic [31:0] sine_entry(input int unsigned n,
                                             input int unsigned addr_bits,
                                             input int unsigned amp_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    longint unsigned d;
    longint unsigned amp_max;
    amp_max = (64'd1 << (amp_bits - 1)) - 64'd1;
    x  = (HALF_PI_Q30 * longint'(n) + (64'd1 << (addr_bits - 1))) >> addr_bits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int k = 7; k >= 1; k--) begin
      d = longint'(2 * k) * longint'(2 * k + 1);
      t = Q30_ONE - udiv64((x2 * t) >> 30, d);
    end
    s = (x * t) >> 30;
    v = (s * amp_max + (64'd1 << 29)) >> 30;
    if (v > amp_max) begin
      v = amp_max;
    end
    return v[31:0];
  endfunction

endpackage : lcg_pkg
`default_nettype wire

[hw/rtl/lcg_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_in_if: tick request channel
// Valid/ready channel carrying the restart flag of one tick.
// ----------------------------------------------------------------------------
interface lcg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface : lcg_in_if
`default_nettype wire

[hw/rtl/lcg_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_out_if: I/Q sample channel
// Valid/ready channel carrying one complex sample and the end-of-chirp flag.
// ----------------------------------------------------------------------------
interface lcg_out_if #(
  parameter int unsigned AMP_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [AMP_BITS-1:0] i_value;
  logic signed [AMP_BITS-1:0] q_value;
  logic                       last;

  modport source (output valid, output i_value, output q_value, output last, input ready);
  modport sink   (input valid, input i_value, input q_value, input last, output ready);
endinterface : lcg_out_if
`default_nettype wire

[hw/rtl/lcg_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_cfg_if: register write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface lcg_cfg_if
  import lcg_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : lcg_cfg_if
`default_nettype wire

[hw/rtl/lcg_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_front: chirp sequencer
// Holds the registers and the chirp state, takes tick requests, classifies
// each as restart, sample or no-op, and pushes the phase of every sample
// into the queue. Phase and step advance once per emitted sample.
// ----------------------------------------------------------------------------
module lcg_front
  import lcg_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned COUNT_BITS      = 24,
  localparam int unsigned ENTRY_BITS     = TABLE_ADDR_BITS + 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  lcg_in_if.sink                     in_chan,
  lcg_cfg_if.sink                    cfg_chan,
  output logic                       push_o,
  output logic [ENTRY_BITS-1:0]      entry_o,
  input  wire logic                  full_i
);

  // Configuration registers
  logic [START_STEP_BITS-1:0]          start_step_q;
  logic signed [STEP_INC_BITS-1:0]     step_inc_q;
  logic [SAMPLE_COUNT_BITS-1:0]        sample_count_q;

  // Chirp state
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] step_q, step_d;
  logic [COUNT_BITS-1:0] done_q, done_d;
  logic                  running_q, running_d;

  logic                  accept;
  logic                  emit;
  logic                  last;
  logic [COUNT_BITS-1:0] limit;
  logic [COUNT_BITS:0]   done_inc;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !full_i;
  assign accept         = in_chan.valid && in_chan.ready;

  assign limit    = COUNT_BITS'(sample_count_q);
  assign done_inc = {1'b0, done_q} + 1'b1;
  assign last     = done_inc >= {1'b0, limit};
  assign emit     = accept && !in_chan.restart && running_q && (done_q < limit);

  // Next chirp state
  always_comb begin
    phase_d   = phase_q;
    step_d    = step_q;
    done_d    = done_q;
    running_d = running_q;
    if (accept) begin
      if (in_chan.restart) begin
        phase_d   = '0;
        step_d    = PHASE_BITS'(start_step_q);
        done_d    = '0;
        running_d = 1'b1;
      end else if (emit) begin
        phase_d = phase_q + step_q;
        step_d  = step_q + PHASE_BITS'(step_inc_q);
        done_d  = done_inc[COUNT_BITS-1:0];
        if (last) begin
          running_d = 1'b0;
        end
      end else begin
        // idle tick, or count already reached
        running_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_step_q   <= '0;
      step_inc_q     <= '0;
      sample_count_q <= '0;
      phase_q        <= '0;
      step_q         <= '0;
      done_q         <= '0;
      running_q      <= 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (reg_idx_e'(cfg_chan.index))
          REG_START_STEP:   start_step_q   <= cfg_chan.data[START_STEP_BITS-1:0];
          REG_STEP_INC:     step_inc_q     <= cfg_chan.data[STEP_INC_BITS-1:0];
          REG_SAMPLE_COUNT: sample_count_q <= cfg_chan.data[SAMPLE_COUNT_BITS-1:0];
          default: ;
        endcase
      end
      phase_q   <= phase_d;
      step_q    <= step_d;
      done_q    <= done_d;
      running_q <= running_d;
    end
  end

  // Queue entry: quadrant, table address, last flag
  assign push_o  = emit;
  assign entry_o = {phase_q[PHASE_BITS-1 -: 2],
                    phase_q[PHASE_BITS-3 -: TABLE_ADDR_BITS],
                    last};

  // The final sample of a chirp always leaves the sequencer idle
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o[0]) |=> !running_q)
    else $error("chirp still running after its last sample");

endmodule : lcg_front
`default_nettype wire

[hw/rtl/lcg_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_fifo: decoupling queue
// Small register queue between the sequencer and the lookup pipeline.
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module lcg_fifo
  import lcg_pkg::*;
#(
  parameter int unsigned WIDTH = 13,
  localparam int unsigned PTR_BITS = $clog2(FIFO_DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0]    mem_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q;
  logic [PTR_BITS-1:0] rd_ptr_q;
  logic [PTR_BITS:0]   count_q;
  logic                do_push;
  logic                do_pop;

  assign full_o  = count_q == (PTR_BITS+1)'(FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_BITS+1)'(FIFO_DEPTH))
    else $error("queue level out of range");

endmodule : lcg_fifo
`default_nettype wire

[hw/rtl/lcg_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_back: sine lookup and output stage
// Reads the quarter-wave table at a and N-a (registered), folds the two
// magnitudes into cos/sin by quadrant and holds the sample in the output
// register until it is taken.
// ----------------------------------------------------------------------------
module lcg_back
  import lcg_pkg::*;
#(
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned AMP_BITS        = 16,
  localparam int unsigned ENTRY_BITS     = TABLE_ADDR_BITS + 3,
  localparam int unsigned TBL_N          = 1 << TABLE_ADDR_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  empty_i,
  input  wire logic [ENTRY_BITS-1:0] entry_i,
  output logic                       pop_o,
  lcg_out_if.source                  out_chan
);

  // Quarter-wave table, built at elaboration
  logic [AMP_BITS-2:0] rom [TBL_N+1];
  for (genvar n = 0; n <= TBL_N; n++) begin : g_rom
    localparam logic [31:0] Entry = sine_entry(n, TABLE_ADDR_BITS, AMP_BITS);
    assign rom[n] = Entry[AMP_BITS-2:0];
  end

  logic [TABLE_ADDR_BITS-1:0] addr;
  logic [TABLE_ADDR_BITS:0]   addr_lo;
  logic [TABLE_ADDR_BITS:0]   addr_hi;
  logic                       advance;

  // Lookup stage
  logic                s1_valid_q;
  logic [AMP_BITS-2:0] s1_lo_q;
  logic [AMP_BITS-2:0] s1_hi_q;
  quad_e               s1_quad_q;
  logic                s1_last_q;

  // Output stage
  logic                       out_valid_q;
  logic signed [AMP_BITS-1:0] out_i_q, out_i_d;
  logic signed [AMP_BITS-1:0] out_q_q, out_q_d;
  logic                       out_last_q;

  logic [AMP_BITS-1:0] pos_lo, pos_hi, neg_lo, neg_hi;

  assign advance = !out_valid_q || out_chan.ready;
  assign pop_o   = advance && !empty_i;
  assign addr    = entry_i[TABLE_ADDR_BITS:1];
  assign addr_lo = {1'b0, addr};
  assign addr_hi = (TABLE_ADDR_BITS+1)'(TBL_N) - addr_lo;

  // Table read, registered
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_lo_q   <= rom[addr_lo];
      s1_hi_q   <= rom[addr_hi];
      s1_quad_q <= quad_e'(entry_i[ENTRY_BITS-1 -: 2]);
      s1_last_q <= entry_i[0];
    end
  end

  // Quadrant folding
  assign pos_lo = {1'b0, s1_lo_q};
  assign pos_hi = {1'b0, s1_hi_q};
  assign neg_lo = ~pos_lo + 1'b1;
  assign neg_hi = ~pos_hi + 1'b1;

  always_comb begin
    case (s1_quad_q)
      QUAD_0: begin
        out_i_d = pos_hi;
        out_q_d = pos_lo;
      end
      QUAD_1: begin
        out_i_d = neg_lo;
        out_q_d = pos_hi;
      end
      QUAD_2: begin
        out_i_d = neg_hi;
        out_q_d = neg_lo;
      end
      default: begin
        out_i_d = pos_lo;
        out_q_d = neg_hi;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_i_q    <= out_i_d;
      out_q_q    <= out_q_d;
      out_last_q <= s1_last_q;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_o;
      out_valid_q <= s1_valid_q;
    end
  end

  assign out_chan.valid   = out_valid_q;
  assign out_chan.i_value = out_i_q;
  assign out_chan.q_value = out_q_q;
  assign out_chan.last    = out_last_q;

  // A sample in the lookup stage is never dropped while the output stalls
  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("lookup stage lost a sample under stall");

endmodule : lcg_back
`default_nettype wire

[hw/rtl/linear_chirp_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_chirp_generator: linear FM chirp source
// Quadratic-phase DDS producing Q1.15 I/Q samples from a quarter-wave table.
// ----------------------------------------------------------------------------
// Each accepted tick request either restarts the chirp (no sample), emits one
// I/Q sample, or does nothing once the chirp is over. The block takes one
// request per clock while the queue is not full and delivers one sample per
// clock while the output takes it; on its way out a sample passes the queue
// (written at the accepting edge), the registered table read and the output
// register. Throughput is set by the sequencer's phase and step update.
// Requests stall only when the queue is full, which happens when the output
// side holds off. Registers are to be written through the configuration
// channel only while no sample is in flight; the block does not enforce this.
// step_increment applies at once and start_step at the next restart.
// ----------------------------------------------------------------------------
module linear_chirp_generator
  import lcg_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned AMP_BITS        = 16,
  parameter int unsigned COUNT_BITS      = 24
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lcg_in_if.sink     in_chan,
  lcg_cfg_if.sink    cfg_chan,
  lcg_out_if.source  out_chan
);

  localparam int unsigned EntryBits = TABLE_ADDR_BITS + 3;

  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  logic [EntryBits-1:0] wr_entry;
  logic [EntryBits-1:0] rd_entry;

  // Sequencer
  lcg_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .push_o   (push),
    .entry_o  (wr_entry),
    .full_i   (full)
  );

  // Decoupling queue
  lcg_fifo #(
    .WIDTH (EntryBits)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wr_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (rd_entry)
  );

  // Lookup and output
  lcg_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .AMP_BITS        (AMP_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .entry_i  (rd_entry),
    .pop_o    (pop),
    .out_chan (out_chan)
  );

endmodule : linear_chirp_generator
`default_nettype wire
